FILE: rtl/core/pdi_pkg.sv
package pdi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int ROOT_W     = 32;
  localparam int SUM_W      = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int DIST_W     = 16;

  localparam logic [ROOT_W-1:0] ROOT_START_MASK = 32'h4000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX        = 16'h7FFF;
  localparam logic [SUM_W-1:0]  DIST_MAX_SQ     = SUM_W'(32767 * 32767);

  localparam logic OP_DIST_2D = 1'b0;
  localparam logic OP_DIST_3D = 1'b1;

  // Work item handed along the row of root cells.
  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic              sat;
    logic              two_d;
  } root_item_t;

  // Takes the low COORD_BITS of a field and sign-extends them.
  function automatic logic signed [DIFF_W-1:0] coord_ext(input logic [FIELD_W-1:0] raw);
    logic signed [COORD_BITS-1:0] c;
    c = raw[COORD_BITS-1:0];
    return DIFF_W'(c);
  endfunction

endpackage

FILE: rtl/core/point_distance_isqrt.sv
// Throughput: one request per cycle while the response side does not hold.
// There are 4 front stages (difference, square, two sums), then 16 root cells,
// one result bit each, then the rounding output register.
// Bubbles collapse, so requests keep entering while a result waits to be taken.
// Reset (rst, synchronous) empties the pipeline and clears long_distance_mode.
module point_distance_isqrt
  import pdi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               op,
  input  logic [FIELD_W-1:0] first_x,
  input  logic [FIELD_W-1:0] first_y,
  input  logic [FIELD_W-1:0] first_z,
  input  logic [FIELD_W-1:0] second_x,
  input  logic [FIELD_W-1:0] second_y,
  input  logic [FIELD_W-1:0] second_z,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [DIST_W-1:0]  distance
);

  logic       long_distance_mode;
  logic       cell_valid [ROOT_STEPS+1];
  logic       cell_stall [ROOT_STEPS+1];
  root_item_t cell_item  [ROOT_STEPS+1];

  root_item_t        last;
  logic [DIST_W:0]   rounded;
  logic [DIST_W-1:0] distance_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_distance_mode <= 1'b0;
    end else if (cfg_write) begin
      long_distance_mode <= cfg_data;
    end
  end

  pdi_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .op        (op),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_z   (first_z),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_z  (second_z),
    .out_valid (cell_valid[0]),
    .out_stall (cell_stall[0]),
    .out_item  (cell_item[0])
  );

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
    pdi_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(k)),
      .in_valid  (cell_valid[k]),
      .in_stall  (cell_stall[k]),
      .in_item   (cell_item[k]),
      .out_valid (cell_valid[k+1]),
      .out_stall (cell_stall[k+1]),
      .out_item  (cell_item[k+1])
    );
  end

  assign cell_stall[ROOT_STEPS] = rsp_valid && rsp_stall;

  // After sixteen steps the floor root fits in 16 bits; rounding may carry to 65536.
  always_comb begin
    last    = cell_item[ROOT_STEPS];
    rounded = last.root[DIST_W:0] + (DIST_W+1)'(last.rem > last.root);
    if (last.sat) begin
      distance_next = DIST_MAX;
    end else if (last.two_d && long_distance_mode && (rounded > (DIST_W+1)'(DIST_MAX))) begin
      distance_next = DIST_MAX;
    end else begin
      distance_next = rounded[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!cell_stall[ROOT_STEPS]) begin
      rsp_valid <= cell_valid[ROOT_STEPS];
    end
    if (!cell_stall[ROOT_STEPS]) begin
      distance <= distance_next;
    end
  end

  // The input can only be held back when the output side is holding.
  a_stall_origin : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_stall)
    else $error("request stalled while the response side is free");

  // A taken result with nothing behind it leaves the output empty.
  a_drain : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !cell_valid[ROOT_STEPS] |=> !rsp_valid)
    else $error("response repeated after it was taken");

  // A held result keeps its value.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(distance))
    else $error("held response changed");

endmodule

FILE: rtl/core/pdi_prep.sv
module pdi_prep
  import pdi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [FIELD_W-1:0] first_x,
  input  logic [FIELD_W-1:0] first_y,
  input  logic [FIELD_W-1:0] first_z,
  input  logic [FIELD_W-1:0] second_x,
  input  logic [FIELD_W-1:0] second_y,
  input  logic [FIELD_W-1:0] second_z,
  output logic               out_valid,
  input  logic               out_stall,
  output root_item_t         out_item
);

  logic                     v1, v2, v3;
  logic                     op1, op2, op3;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]          sqx, sqy, sqz, sqz3;
  logic [SQ_W:0]            sum2;
  logic                     st1, st2, st3, st4;

  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SUM_W-1:0]           sum2_ext, sum3;
  logic                       over;
  root_item_t                 item_next;

  // A stage holds only when it is full and the stage after it holds.
  assign st4      = out_valid && out_stall;
  assign st3      = v3 && st4;
  assign st2      = v2 && st3;
  assign st1      = v1 && st2;
  assign in_stall = st1;

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_comb begin
    sum2_ext        = SUM_W'(sum2);
    sum3            = sum2_ext + SUM_W'(sqz3);
    over            = (sum3 >= DIST_MAX_SQ);
    item_next.root  = '0;
    item_next.two_d = (op3 == OP_DIST_2D);
    item_next.sat   = (op3 == OP_DIST_3D) && over;
    if (op3 == OP_DIST_3D) begin
      item_next.rem = sum3[ROOT_W-1:0];
    end else begin
      item_next.rem = sum2_ext[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!st1) v1 <= in_valid;
      if (!st2) v2 <= v1;
      if (!st3) v3 <= v2;
      if (!st4) out_valid <= v3;
    end
    if (!st1) begin
      op1 <= op;
      dx  <= coord_ext(second_x) - coord_ext(first_x);
      dy  <= coord_ext(second_y) - coord_ext(first_y);
      dz  <= coord_ext(second_z) - coord_ext(first_z);
    end
    if (!st2) begin
      op2 <= op1;
      sqx <= px[SQ_W-1:0];
      sqy <= py[SQ_W-1:0];
      sqz <= pz[SQ_W-1:0];
    end
    if (!st3) begin
      op3  <= op2;
      sum2 <= {1'b0, sqx} + {1'b0, sqy};
      sqz3 <= sqz;
    end
    if (!st4) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: rtl/core/pdi_root_cell.sv
module pdi_root_cell
  import pdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [STEP_W-1:0] step,
  input  logic              in_valid,
  output logic              in_stall,
  input  root_item_t        in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output root_item_t        out_item
);

  logic [ROOT_W-1:0] mask;
  logic [ROOT_W-1:0] trial;
  root_item_t        item_next;

  assign in_stall = out_valid && out_stall;

  // One restoring step: the trial bit pair for this cell is fixed by its place.
  always_comb begin
    mask      = ROOT_START_MASK >> {step, 1'b0};
    trial     = in_item.root + mask;
    item_next = in_item;
    if (trial <= in_item.rem) begin
      item_next.rem  = in_item.rem - trial;
      item_next.root = (trial + mask) >> 1;
    end else begin
      item_next.root = in_item.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
    if (!in_stall) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: verif/tb_point_distance_isqrt.sv
`timescale 1ns / 1ps

module tb_point_distance_isqrt;
  import pdi_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_REQUESTS  = 135;
  localparam int DIRECTED_ROWS   = 23;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] fx;
    logic [FIELD_W-1:0] fy;
    logic [FIELD_W-1:0] fz;
    logic [FIELD_W-1:0] sx;
    logic [FIELD_W-1:0] sy;
    logic [FIELD_W-1:0] sz;
  } dist_req_t;

  typedef struct packed {
    logic              mode;
    dist_req_t         req;
    logic              known;
    logic [DIST_W-1:0] known_dist;
  } dist_row_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_data  = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               op        = OP_DIST_2D;
  logic [FIELD_W-1:0] first_x   = '0;
  logic [FIELD_W-1:0] first_y   = '0;
  logic [FIELD_W-1:0] first_z   = '0;
  logic [FIELD_W-1:0] second_x  = '0;
  logic [FIELD_W-1:0] second_y  = '0;
  logic [FIELD_W-1:0] second_z  = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [DIST_W-1:0]  distance;

  logic [DIST_W-1:0] awaited_dist[$];
  logic              long_mode     = 1'b0;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  int                errors        = 0;
  int                quiet_cycles  = 0;
  logic [DIST_W-1:0] head_dist;
  dist_row_t         directed[DIRECTED_ROWS];

  point_distance_isqrt uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .op       (op),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_z  (first_z),
    .second_x (second_x),
    .second_y (second_y),
    .second_z (second_z),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .distance (distance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint coord_of(logic [FIELD_W-1:0] raw);
    logic signed [COORD_BITS-1:0] c;
    c = raw[COORD_BITS-1:0];
    return longint'(c);
  endfunction

  // Restoring square root, one result bit per pass, rounded to nearest.
  function automatic logic [31:0] round_root(logic [31:0] value);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] mask;
    logic [31:0] trial;
    rem  = value;
    root = '0;
    mask = 32'h4000_0000;
    while (mask != 0) begin
      trial = root + mask;
      if (trial <= rem) begin
        rem  = rem - trial;
        root = trial + mask;
      end
      root = root >> 1;
      mask = mask >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(dist_req_t r, logic sat_mode);
    longint          dx;
    longint          dy;
    longint          dz;
    longint unsigned sum;
    logic [31:0]     root;
    dx  = coord_of(r.sx) - coord_of(r.fx);
    dy  = coord_of(r.sy) - coord_of(r.fy);
    dz  = coord_of(r.sz) - coord_of(r.fz);
    sum = longint'(dx * dx) + longint'(dy * dy);
    if (r.op == OP_DIST_3D) begin
      sum = sum + longint'(dz * dz);
      if (sum < longint'(DIST_MAX) * longint'(DIST_MAX)) root = round_root(sum[31:0]);
      else root = {16'd0, DIST_MAX};
    end else begin
      // Only the low 32 bits of the planar sum reach the root.
      root = round_root(sum[31:0]);
      if (sat_mode && root > {16'd0, DIST_MAX}) root = {16'd0, DIST_MAX};
    end
    return root[DIST_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] random_coord();
    int unsigned        k;
    logic [FIELD_W-1:0] c;
    k = $urandom_range(0, 9);
    if (k < 4) c = FIELD_W'($urandom);
    else if (k < 6) c = FIELD_W'(int'($urandom_range(0, 32767)) - 16384);
    else if (k < 8) c = FIELD_W'(int'($urandom_range(0, 400)) - 200);
    else begin
      case ($urandom_range(0, 5))
        0: c = 16'h8000;
        1: c = 16'h8001;
        2: c = 16'hFFFF;
        3: c = 16'h0000;
        4: c = 16'h7FFE;
        default: c = 16'h7FFF;
      endcase
    end
    return c;
  endfunction

  function automatic dist_req_t random_request();
    dist_req_t r;
    r.op = $urandom_range(0, 1) ? OP_DIST_3D : OP_DIST_2D;
    r.fx = random_coord();
    r.fy = random_coord();
    r.fz = random_coord();
    // A quarter of the requests put the second point close to the first.
    if ($urandom_range(0, 3) == 0) begin
      r.sx = r.fx + FIELD_W'(int'($urandom_range(0, 64)) - 32);
      r.sy = r.fy + FIELD_W'(int'($urandom_range(0, 64)) - 32);
      r.sz = r.fz + FIELD_W'(int'($urandom_range(0, 64)) - 32);
    end else begin
      r.sx = random_coord();
      r.sy = random_coord();
      r.sz = random_coord();
    end
    return r;
  endfunction

  task automatic send_request(dist_req_t r, int gap, logic [DIST_W-1:0] want);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    op        <= r.op;
    first_x   <= r.fx;
    first_y   <= r.fy;
    first_z   <= r.fz;
    second_x  <= r.sx;
    second_y  <= r.sy;
    second_z  <= r.sz;
    do @(posedge clk); while (req_stall);
    awaited_dist.push_back(want);
  endtask

  task automatic wait_results_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited_dist.size() != 0);
  endtask

  task automatic write_long_mode(logic m);
    wait_results_drained();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    long_mode = m;
  endtask

  function automatic int random_gap();
    int g;
    g = 0;
    while (int'($urandom_range(0, 99)) < send_idle_pct) g++;
    return g;
  endfunction

  // Checks each accepted distance, runs the idle watchdog and drives the receiver's stall.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_dist.size() == 0) begin
        if (errors < 10) $display("unexpected distance %0d", $signed(distance));
        errors++;
      end else begin
        head_dist = awaited_dist.pop_front();
        if (distance !== head_dist) begin
          if (errors < 10)
            $display("distance mismatch: expected %0d actual %0d",
                     $signed(head_dist), $signed(distance));
          errors++;
        end
      end
    end
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
    rsp_stall <= (int'($urandom_range(0, 99)) < stall_pct);
  end

  initial begin : stimulus
    int        ph;
    int        i;
    dist_req_t r;
    logic [DIST_W-1:0] want;

    directed[0]  = '{1'b0, '{OP_DIST_2D, 0, 0, 0, 0, 0, 0}, 1'b1, 16'd0};
    directed[1]  = '{1'b0, '{OP_DIST_3D, 0, 0, 0, 0, 0, 0}, 1'b1, 16'd0};
    directed[2]  = '{1'b0, '{OP_DIST_2D, 0, 0, 0, 3, 4, 0}, 1'b1, 16'd5};
    directed[3]  = '{1'b0, '{OP_DIST_3D, 0, 0, 0, 2, 3, 6}, 1'b1, 16'd7};
    directed[4]  = '{1'b0, '{OP_DIST_2D, 0, 0, 0, 2, 3, 6}, 1'b0, 16'd0};
    directed[5]  = '{1'b0, '{OP_DIST_2D, 0, 0, 0, 2, 2, 0}, 1'b0, 16'd0};
    directed[6]  = '{1'b0, '{OP_DIST_2D, 0, 0, 0, 1, 1, 0}, 1'b0, 16'd0};
    directed[7]  = '{1'b0, '{OP_DIST_2D, 0, 0, 0, -32768, 0, 0}, 1'b1, 16'h8000};
    directed[8]  = '{1'b0, '{OP_DIST_2D, -32768, 0, 0, 32767, 256, 0}, 1'b1, 16'd0};
    directed[9]  = '{1'b0, '{OP_DIST_2D, -32768, -32768, 0, 32767, 32767, 0}, 1'b0, 16'd0};
    directed[10] = '{1'b0, '{OP_DIST_2D, 32767, 32767, 0, -32768, -32768, 0}, 1'b0, 16'd0};
    directed[11] = '{1'b0, '{OP_DIST_3D, -32768, -32768, -32768, 32767, 32767, 32767},
                     1'b1, 16'h7FFF};
    directed[12] = '{1'b0, '{OP_DIST_3D, 0, 0, 0, 32767, 0, 0}, 1'b1, 16'h7FFF};
    directed[13] = '{1'b0, '{OP_DIST_3D, 0, 0, 0, 32766, 255, 0}, 1'b0, 16'd0};
    directed[14] = '{1'b0, '{OP_DIST_3D, 100, -200, 300, -300, 400, -500}, 1'b0, 16'd0};
    directed[15] = '{1'b1, '{OP_DIST_2D, 0, 0, 0, 3, 4, 0}, 1'b1, 16'd5};
    directed[16] = '{1'b1, '{OP_DIST_2D, 0, 0, 0, -32768, 0, 0}, 1'b1, 16'h7FFF};
    directed[17] = '{1'b1, '{OP_DIST_2D, -32768, 0, 0, 32767, 256, 0}, 1'b1, 16'h7FFF};
    directed[18] = '{1'b1, '{OP_DIST_2D, -32768, -32768, 0, 32767, 32767, 0}, 1'b0, 16'd0};
    directed[19] = '{1'b1, '{OP_DIST_2D, 0, 0, 0, -32767, 0, 0}, 1'b1, 16'h7FFF};
    directed[20] = '{1'b1, '{OP_DIST_3D, -32768, -32768, -32768, 32767, 32767, 32767},
                     1'b1, 16'h7FFF};
    directed[21] = '{1'b1, '{OP_DIST_2D, 100, -200, 0, -300, 400, 0}, 1'b0, 16'd0};
    directed[22] = '{1'b1, '{OP_DIST_2D, 0, 0, 0, 0, 0, 0}, 1'b1, 16'd0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed rows start on the reset setting, legacy wrap.
    send_idle_pct = 36;
    stall_pct     = 36;
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed[i].mode != long_mode) write_long_mode(directed[i].mode);
      r    = directed[i].req;
      want = directed[i].known ? directed[i].known_dist : predict_distance(r, long_mode);
      send_request(r, random_gap(), want);
    end

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      write_long_mode(logic'((ph + ph / 4) % 2));
      for (i = 0; i < PHASE_REQUESTS; i++) begin
        // Halfway through, the sender holds off until the pipeline is empty.
        if (i == PHASE_REQUESTS / 2) wait_results_drained();
        r = random_request();
        send_request(r, random_gap(), predict_distance(r, long_mode));
      end
    end

    req_valid <= 1'b0;
    while (awaited_dist.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && awaited_dist.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
